FILE: hw/rtl/bcte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcte_pkg
// Shared types, constants and calendar helpers of the BCD calendar converter.
// ----------------------------------------------------------------------------
package bcte_pkg;

  localparam int unsigned TS_W  = 32;
  localparam int unsigned DAY_W = 16;

  // register index, byte address is 4 * index
  localparam logic        REG_TICK_PERIOD = 1'b0;

  localparam logic [7:0]  EPOCH_YEAR_OFS = 8'd25;   // 2025 minus 2000
  localparam logic [7:0]  CENTURY_OFS    = 8'd100;  // 2100, not a leap year
  localparam logic [31:0] SEC_PER_DAY    = 32'd86400;
  localparam logic [31:0] MS_PER_SEC     = 32'd1000;
  localparam logic [31:0] DAYS_PER_YEAR  = 32'd365;

  typedef struct packed {
    logic load;
    logic year_step;
    logic add_md;
    logic mul_day;
    logic add_sod;
    logic mul_ms;
    logic emit;
  } bcte_cmd_t;

  typedef struct packed {
    logic year_done;
  } bcte_sts_t;

  // year given as offset from 2000, valid for 2000 to 2199
  function automatic logic leap_ofs(input logic [7:0] y);
    return (y[1:0] == 2'b00) && (y != CENTURY_OFS);
  endfunction

  // cumulative days before the start of a month (index 0 is january)
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    base = 9'd0;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // two bcd nibbles taken arithmetically
  function automatic logic [7:0] bcd_val(input logic [3:0] hi, input logic [3:0] lo);
    logic [7:0] tens;
    tens = {4'd0, hi} * 8'd10;
    return tens + {4'd0, lo};
  endfunction

endpackage

FILE: hw/rtl/bcte_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcte_in_if
// Input channel: bcd time word, bcd date word and signed tick count.
// ----------------------------------------------------------------------------
interface bcte_in_if;
  logic               valid;
  logic               ready;
  logic [21:0]        time_word;
  logic [23:0]        date_word;
  logic signed [31:0] elapsed_ticks;

  modport source (output valid, time_word, date_word, elapsed_ticks, input ready);
  modport sink   (input valid, time_word, date_word, elapsed_ticks, output ready);
endinterface

FILE: hw/rtl/bcte_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcte_out_if
// Result channel: millisecond timestamp, day count and month error flag.
// ----------------------------------------------------------------------------
interface bcte_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] timestamp_ms;
  logic [15:0] day_count;
  logic        bad_month;

  modport source (output valid, timestamp_ms, day_count, bad_month, input ready);
  modport sink   (input valid, timestamp_ms, day_count, bad_month, output ready);
endinterface

FILE: hw/rtl/bcte_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcte_dp
// Datapath: bcd decode, year accumulation, month/day offset, multiplies and
// the output word register.
// ----------------------------------------------------------------------------
module bcte_dp
  import bcte_pkg::*;
(
  input  logic              clk,
  input  bcte_cmd_t         cmd,
  output bcte_sts_t         sts,
  input  logic [21:0]       time_word,
  input  logic [23:0]       date_word,
  input  logic [31:0]       elapsed_ticks,
  input  logic [9:0]        tick_period_ms,
  output logic [TS_W-1:0]   timestamp_ms,
  output logic [DAY_W-1:0]  day_count,
  output logic              bad_month
);

  logic [7:0]  yo_r,    yo_nxt;
  logic [7:0]  y_r,     y_nxt;
  logic [4:0]  month_r, month_nxt;
  logic [5:0]  day_r,   day_nxt;
  logic [17:0] sod_r,   sod_nxt;
  logic [31:0] tk_r,    tk_nxt;
  logic [9:0]  per_r,   per_nxt;
  logic [31:0] days_r,  days_nxt;
  logic [31:0] prod_r,  prod_nxt;
  logic [31:0] delta_r, delta_nxt;
  logic        bad_r,   bad_nxt;
  logic [31:0] ts_r,    ts_nxt;
  logic [15:0] dc_r,    dc_nxt;
  logic        ob_r,    ob_nxt;

  logic [7:0]  hr_v, mn_v, sc_v;
  logic [17:0] sod_calc;
  logic        month_bad;
  logic [3:0]  month_idx;
  logic [8:0]  month_ofs;
  logic        tk_pos;

  always_comb begin
    hr_v     = bcd_val({2'b00, time_word[21:20]}, time_word[19:16]);
    mn_v     = bcd_val({1'b0, time_word[14:12]}, time_word[11:8]);
    sc_v     = bcd_val({1'b0, time_word[6:4]}, time_word[3:0]);
    sod_calc = {10'd0, hr_v} * 18'd3600 + {10'd0, mn_v} * 18'd60 + {10'd0, sc_v};
  end

  assign month_bad = (month_r < 5'd1) || (month_r > 5'd12);
  assign month_idx = 4'(month_r - 5'd1);
  assign month_ofs = month_bad ? 9'd0 : month_start(leap_ofs(yo_r), month_idx);
  assign tk_pos    = !tk_r[31] && (tk_r != 32'd0);

  assign sts.year_done = (y_r >= yo_r);

  always_comb begin
    yo_nxt    = yo_r;
    y_nxt     = y_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    sod_nxt   = sod_r;
    tk_nxt    = tk_r;
    per_nxt   = per_r;
    days_nxt  = days_r;
    prod_nxt  = prod_r;
    delta_nxt = delta_r;
    bad_nxt   = bad_r;
    ts_nxt    = ts_r;
    dc_nxt    = dc_r;
    ob_nxt    = ob_r;
    if (cmd.load) begin
      yo_nxt    = bcd_val(date_word[23:20], date_word[19:16]);
      month_nxt = 5'(bcd_val({3'b000, date_word[12]}, date_word[11:8]));
      day_nxt   = 6'(bcd_val({2'b00, date_word[5:4]}, date_word[3:0]));
      sod_nxt   = sod_calc;
      tk_nxt    = elapsed_ticks;
      per_nxt   = tick_period_ms;
      y_nxt     = EPOCH_YEAR_OFS;
      days_nxt  = 32'd0;
    end
    if (cmd.year_step) begin
      days_nxt = days_r + DAYS_PER_YEAR + {31'd0, leap_ofs(y_r)};
      y_nxt    = y_r + 8'd1;
    end
    if (cmd.add_md) begin
      days_nxt = days_r + {23'd0, month_ofs} + {26'd0, day_r} - 32'd1;
      bad_nxt  = month_bad;
    end
    if (cmd.mul_day) begin
      prod_nxt  = days_r * SEC_PER_DAY;
      delta_nxt = tk_pos ? (tk_r * {22'd0, per_r}) : 32'd0;
    end
    if (cmd.add_sod) begin
      prod_nxt = prod_r + {14'd0, sod_r};
    end
    if (cmd.mul_ms) begin
      prod_nxt = prod_r * MS_PER_SEC;
    end
    if (cmd.emit) begin
      ts_nxt = prod_r + delta_r;
      dc_nxt = days_r[15:0];
      ob_nxt = bad_r;
    end
  end

  always_ff @(posedge clk) begin
    yo_r    <= yo_nxt;
    y_r     <= y_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    sod_r   <= sod_nxt;
    tk_r    <= tk_nxt;
    per_r   <= per_nxt;
    days_r  <= days_nxt;
    prod_r  <= prod_nxt;
    delta_r <= delta_nxt;
    bad_r   <= bad_nxt;
    ts_r    <= ts_nxt;
    dc_r    <= dc_nxt;
    ob_r    <= ob_nxt;
  end

  assign timestamp_ms = ts_r;
  assign day_count    = dc_r;
  assign bad_month    = ob_r;

endmodule

FILE: hw/rtl/bcte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcte_ctrl
// Sequencer: accepts a word, steps the year loop, orders the arithmetic and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module bcte_ctrl
  import bcte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bcte_sts_t sts,
  output bcte_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_YEAR,
    S_MD,
    S_MULD,
    S_SOD,
    S_MULMS,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (sts.year_done) begin
          state_nxt = S_MD;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MD: begin
        cmd.add_md = 1'b1;
        state_nxt  = S_MULD;
      end
      S_MULD: begin
        cmd.mul_day = 1'b1;
        state_nxt   = S_SOD;
      end
      S_SOD: begin
        cmd.add_sod = 1'b1;
        state_nxt   = S_MULMS;
      end
      S_MULMS: begin
        cmd.mul_ms = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_YEAR))
    else $error("accepted word did not start the year loop");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> slot_free)
    else $error("result word overwritten while pending");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted word not presented");

  a_year_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_YEAR && !sts.year_done) |=> (state_r == S_YEAR))
    else $error("year loop left early");

endmodule

FILE: hw/rtl/bcd_calendar_to_epoch_ms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_calendar_to_epoch_ms
// BCD date and time to milliseconds since 2025-01-01 plus scaled tick offset.
// ----------------------------------------------------------------------------
// the day accumulation loop adds one year per cycle over N = max(0, year - 2025)
//   years, then month/day offset, day multiply, seconds add and ms multiply
//   follow in order before the result is registered; the next word is accepted
//   once the result is registered, even while that result still waits on the output
// reset: synchronous active low, clears sequencer and valid, period reads 1
// ----------------------------------------------------------------------------
module bcd_calendar_to_epoch_ms
  import bcte_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  bcte_in_if.sink       in_ch,
  bcte_out_if.source    out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [9:0] period_r, period_nxt;
  logic       cfg_wr;
  logic       in_ready;
  logic       out_valid;
  bcte_cmd_t  cmd;
  bcte_sts_t  sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TICK_PERIOD);

  always_comb begin
    period_nxt = period_r;
    if (cfg_wr) begin
      period_nxt = pwdata[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 10'd1;
    end else begin
      period_r <= period_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_TICK_PERIOD) ? {22'd0, period_r} : 32'd0;

  bcte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bcte_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .time_word      (in_ch.time_word),
    .date_word      (in_ch.date_word),
    .elapsed_ticks  (in_ch.elapsed_ticks),
    .tick_period_ms (period_r),
    .timestamp_ms   (out_ch.timestamp_ms),
    .day_count      (out_ch.day_count),
    .bad_month      (out_ch.bad_month)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the BCD calendar to epoch milliseconds converter.
// A directed table covers the field extremes, the ignored bits, bad months,
// day zero, years before the epoch and the tick sign rules. Random words
// follow under several tick periods. Every result word is checked against
// its table value or a calendar predictor while both channels idle in random
// bursts and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb
  import bcte_pkg::*;
();

  localparam int unsigned LIMIT_CYCLES   = 600000;
  localparam int unsigned DRAIN_CYCLES   = 160;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned PHASE_WORDS    = 90;

  typedef struct packed {
    logic [21:0] tw;
    logic [23:0] dw;
    logic [31:0] tk;
  } cal_word_t;

  typedef struct packed {
    logic [TS_W-1:0]  ts;
    logic [DAY_W-1:0] dc;
    logic             bad;
  } stamp_t;

  typedef struct packed {
    cal_word_t w;
    logic      typed;
    stamp_t    e;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bcte_in_if  in_if ();
  bcte_out_if out_if ();

  bcd_calendar_to_epoch_ms DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  int unsigned tick_period;
  int unsigned err_count;
  int unsigned cycles;
  bit          idle_on;
  bit          hold_req;
  stamp_t      pending_stamps[$];
  dir_row_t    dir_rows[$];

  int unsigned cum_days [0:1][0:11] = '{
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334},
    '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335}
  };

  function automatic int unsigned digits(input logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic int unsigned is_leap(input int unsigned y);
    return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 1 : 0;
  endfunction

  function automatic logic [7:0] to_bcd(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic stamp_t calendar_ms(input cal_word_t w);
    int unsigned sod;
    int unsigned yr;
    int unsigned mon;
    int unsigned dd;
    int unsigned days;
    int unsigned delta;
    stamp_t      r;
    sod  = digits({2'b00, w.tw[21:16]}) * 3600 + digits({1'b0, w.tw[14:8]}) * 60
         + digits({1'b0, w.tw[6:0]});
    yr   = 2000 + digits(w.dw[23:16]);
    mon  = digits({3'b000, w.dw[12:8]});
    dd   = digits({2'b00, w.dw[5:0]});
    days = 0;
    for (int unsigned y = 2025; y < yr; y++) begin
      days += (is_leap(y) != 0) ? 366 : 365;
    end
    r.bad = (mon < 1 || mon > 12);
    if (!r.bad) begin
      days += cum_days[is_leap(yr)][mon - 1];
    end
    days += dd - 1;
    delta = 0;
    if (w.tk != 32'd0 && !w.tk[31]) begin
      delta = w.tk * tick_period;
    end
    r.ts = (days * 86400 + sod) * 1000 + delta;
    r.dc = days[15:0];
    return r;
  endfunction

  function automatic cal_word_t rand_word();
    cal_word_t w;
    int unsigned yy;
    if ($urandom_range(0, 9) < 7) begin
      yy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) : $urandom_range(25, 35);
      w.tw = {6'(to_bcd($urandom_range(0, 23))),
              to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59))};
      w.dw = {to_bcd(yy), 3'($urandom), 5'(to_bcd($urandom_range(1, 12))),
              2'b00, 6'(to_bcd($urandom_range(1, 31)))};
    end else begin
      w.tw = 22'($urandom);
      w.dw = 24'($urandom);
    end
    case ($urandom_range(0, 4))
      0:       w.tk = 32'd0;
      1:       w.tk = $urandom_range(1, 100000);
      2:       w.tk = $urandom | 32'h8000_0000;
      3:       w.tk = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       w.tk = 32'h7FFF_FFFF;
          1:       w.tk = 32'h8000_0000;
          2:       w.tk = 32'd1;
          default: w.tk = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return w;
  endfunction

  task automatic dir(input logic [21:0] tw, input logic [23:0] dw, input logic [31:0] tk,
                     input logic typed, input logic [31:0] ts, input logic [15:0] dc,
                     input logic bad);
    dir_row_t r;
    r.w     = '{tw: tw, dw: dw, tk: tk};
    r.typed = typed;
    r.e     = '{ts: ts, dc: dc, bad: bad};
    dir_rows.push_back(r);
  endtask

  task automatic send_word(input cal_word_t w, input stamp_t e);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.time_word     <= w.tw;
    in_if.date_word     <= w.dw;
    in_if.elapsed_ticks <= w.tk;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_stamps.push_back(e);
  endtask

  task automatic drain_and_set_period(input logic [31:0] value);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_stamps.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TICK_PERIOD, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tick_period = value & 32'h3FF;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(input logic [31:0] period);
    cal_word_t w;
    drain_and_set_period(period);
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (i == PHASE_WORDS / 2 && period == 32'd1) begin
        idle_on = 1'b0;
      end
      w = rand_word();
      send_word(w, calendar_ms(w));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // output side: random ready bursts, steady ready once idling stops, and one long hold-off
  initial begin
    int unsigned n;
    int unsigned held;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_req = 1'b0;
      end else if (!idle_on) begin
        out_if.ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 2) != 0) begin
          out_if.ready <= 1'b1;
          n = $urandom_range(1, 60);
        end else begin
          out_if.ready <= 1'b0;
          n = $urandom_range(1, 19);
        end
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    stamp_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_stamps.size() == 0) begin
        $error("unexpected result word ts=%0h dc=%0h bad=%0b",
               out_if.timestamp_ms, out_if.day_count, out_if.bad_month);
        err_count++;
      end else begin
        e = pending_stamps.pop_front();
        if (out_if.timestamp_ms !== e.ts) begin
          $error("timestamp_ms expected %0h actual %0h", e.ts, out_if.timestamp_ms);
          err_count++;
        end
        if (out_if.day_count !== e.dc) begin
          $error("day_count expected %0h actual %0h", e.dc, out_if.day_count);
          err_count++;
        end
        if (out_if.bad_month !== e.bad) begin
          $error("bad_month expected %0b actual %0b", e.bad, out_if.bad_month);
          err_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t r;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_if.valid         = 1'b0;
    in_if.time_word     = '0;
    in_if.date_word     = '0;
    in_if.elapsed_ticks = '0;
    tick_period         = 1;
    err_count           = 0;
    cycles              = 0;
    idle_on             = 1'b1;
    hold_req            = 1'b0;

    // all zero: year 2000, month 0, day 0
    dir(22'h0, 24'h000000, 32'h0, 1'b1, 32'd4208567296, 16'hFFFF, 1'b1);
    dir(22'h0, 24'h250101, 32'h0, 1'b1, 32'd0, 16'd0, 1'b0);
    dir(22'h0, 24'h250101, 32'd5, 1'b1, 32'd5, 16'd0, 1'b0);
    dir(22'h0, 24'h250101, 32'hFFFF_FFFF, 1'b1, 32'd0, 16'd0, 1'b0);
    dir(22'h0, 24'h250101, 32'h8000_0000, 1'b1, 32'd0, 16'd0, 1'b0);
    dir(22'h0, 24'h250101, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 16'd0, 1'b0);
    dir(22'h235959, 24'h250101, 32'h0, 1'b1, 32'd86399000, 16'd0, 1'b0);
    dir(22'h0, 24'h250102, 32'h0, 1'b1, 32'd86400000, 16'd1, 1'b0);
    dir(22'h0, 24'h251301, 32'h0, 1'b1, 32'd0, 16'd0, 1'b1);
    dir(22'h0, 24'h250001, 32'h0, 1'b1, 32'd0, 16'd0, 1'b1);
    // weekday and unused time bits ignored
    dir(22'h0, 24'h25E101, 32'h0, 1'b1, 32'd0, 16'd0, 1'b0);
    dir(22'h008080, 24'h250101, 32'h0, 1'b1, 32'd0, 16'd0, 1'b0);
    dir(22'h0, 24'h241231, 32'h0, 1'b0, '0, '0, 1'b0);
    dir(22'h120000, 24'h280301, 32'd10, 1'b0, '0, '0, 1'b0);
    dir(22'h0, 24'hA00301, 32'h0, 1'b0, '0, '0, 1'b0);
    dir(22'h0, 24'h000229, 32'h0, 1'b0, '0, '0, 1'b0);
    dir(22'h3FFFFF, 24'hFFFFFF, 32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0);
    dir(22'h0A0F0F, 24'h2F1F3F, 32'd1, 1'b0, '0, '0, 1'b0);
    dir(22'h000000, 24'h991231, 32'd1000, 1'b0, '0, '0, 1'b0);
    dir(22'h235959, 24'h251231, 32'd3, 1'b0, '0, '0, 1'b0);
    dir(22'h0, 24'h250100, 32'h0, 1'b0, '0, '0, 1'b0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // output held off while the directed words keep coming
    hold_req = 1'b1;
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_word(r.w, r.typed ? r.e : calendar_ms(r.w));
    end

    random_phase(32'd1000);
    random_phase(32'd0);
    random_phase(32'd1023);
    random_phase($urandom_range(2, 999));
    random_phase(32'd1);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
